// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the pressure-to-altitude block
// Breakpoint table, field widths and the divider status record.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Field widths
    localparam int RAW_W   = 24;  // raw sensor code, signed
    localparam int P_W     = 22;  // pressure in mbar/1000, signed
    localparam int REF_W   = 21;  // reference pressure, unsigned
    localparam int ALT_W   = 32;  // altitude in mm, signed
    localparam int DELTA_W = 24;  // reference minus pressure, signed
    localparam int F_W     = 22;  // interpolated factor, unsigned, always positive
    localparam int SEG_W   = 17;  // segment width, unsigned
    localparam int PROD_W  = DELTA_W * 2;  // signed product of delta and factor

    // Raw code to mbar/1000: multiply by 125, divide by 512
    localparam int CONV_W     = 32;
    localparam int CONV_MUL   = 125;
    localparam int CONV_SHIFT = 9;

    // Breakpoint table, falling pressure
    localparam int BP_COUNT = 8;
    localparam int IDX_W    = $clog2(BP_COUNT);
    localparam int FAC_W    = 5;

    localparam logic signed [P_W-1:0] BP_PRESSURE [BP_COUNT] = '{
        22'sd1225005, 22'sd1118311, 22'sd1012049, 22'sd909702,
        22'sd808871,  22'sd710051,  22'sd614001,  22'sd520296
    };
    localparam logic [FAC_W-1:0] BP_FACTOR [BP_COUNT] = '{
        5'd14, 5'd13, 5'd12, 5'd11, 5'd10, 5'd9, 5'd8, 5'd7
    };

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BP_COUNT - 1);

    // Reset value of the reference pressure
    localparam logic [REF_W-1:0] REF_RESET = 21'd1013250;

    // Pressure span of the segment that starts at idx; the last index divides by one
    function automatic logic [SEG_W-1:0] seg_width(input logic [IDX_W-1:0] idx);
        logic signed [P_W-1:0] diff;
        if (idx == LAST_IDX) begin
            diff = P_W'(1);
        end else begin
            diff = BP_PRESSURE[idx] - BP_PRESSURE[idx + 1'b1];
        end
        return diff[SEG_W-1:0];
    endfunction

    // Upper factor times segment width
    function automatic logic [DELTA_W-1:0] seg_scale(input logic [IDX_W-1:0] idx);
        logic [DELTA_W-1:0] fac;
        logic [DELTA_W-1:0] wid;
        fac = DELTA_W'(BP_FACTOR[idx]);
        wid = DELTA_W'(seg_width(idx));
        return DELTA_W'(fac * wid);
    endfunction

    // Segment selection result
    typedef struct packed {
        logic [F_W-1:0]   factor;
        logic [SEG_W-1:0] width;
    } bpa_seg_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } bpa_div_stat_t;

endpackage

// ===== rtl/bpa_seg.sv =====
// ----------------------------------------------------------------------------
// bpa_seg: breakpoint segment lookup
// Picks the table segment for a pressure and forms the interpolated factor
// and the segment width used as divisor.
// ----------------------------------------------------------------------------
module bpa_seg
    import bpa_pkg::*;
(
    input  logic signed [P_W-1:0] pressure,
    output bpa_seg_t              seg
);

    logic [BP_COUNT-1:0]        at_or_below;
    logic [IDX_W-1:0]           hi_idx;
    logic signed [P_W:0]        d_hi;
    logic signed [DELTA_W-1:0]  f_full;

    // Compare against every breakpoint in parallel
    always_comb begin
        for (int i = 0; i < BP_COUNT; i++) begin
            at_or_below[i] = (pressure <= BP_PRESSURE[i]);
        end
    end

    // Take the highest index whose breakpoint is not below the pressure, else the first
    always_comb begin
        hi_idx = '0;
        for (int i = 0; i < BP_COUNT; i++) begin
            if (at_or_below[i]) begin
                hi_idx = IDX_W'(i);
            end
        end
    end

    // Interpolate: fh*d_lo + fl*d_hi equals fh*width - d_hi since fl = fh - 1
    always_comb begin
        d_hi   = {BP_PRESSURE[hi_idx][P_W-1], BP_PRESSURE[hi_idx]} - {pressure[P_W-1], pressure};
        f_full = $signed(seg_scale(hi_idx)) - {d_hi[P_W], d_hi};
        if (hi_idx == LAST_IDX) begin
            // At or below the lowest breakpoint: last factor, divisor of one
            seg.factor = F_W'(BP_FACTOR[LAST_IDX]);
        end else begin
            seg.factor = f_full[F_W-1:0];
        end
        seg.width = seg_width(hi_idx);
    end

endmodule

// ===== rtl/bpa_div.sv =====
// ----------------------------------------------------------------------------
// bpa_div: iterative unsigned divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpa_div
    import bpa_pkg::*;
#(
    parameter int DVD_W = 48,
    parameter int DVS_W = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output bpa_div_stat_t    stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             done_reg, done_next;
    logic [DVD_W-1:0] quo_reg,  quo_next;
    logic [DVS_W-1:0] rem_reg,  rem_next;
    logic [DVS_W-1:0] dvs_reg,  dvs_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;

    // One restoring step per cycle
    always_comb begin
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            cnt_next = CNT_W'(DVD_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[DVS_W]) begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    // Hold counter, done flag and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

// ===== rtl/baro_pressure_to_altitude_top.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_to_altitude_top: barometric pressure to altitude converter
// Converts raw sensor codes to mbar/1000 and to altitude in mm over a
// piecewise linear table.
// ----------------------------------------------------------------------------
// Each sample goes through these steps from its transfer until the block is
// ready for the next: scale the code, select the segment and multiply, load
// the divider, run the shift-subtract divider that divides the product by
// the segment width, see the divider's done flag, and hand the result to the
// output register. s_tready stays low while a sample is in work. The result
// waits in its own register, so a sample is accepted while the previous
// result is still unread; a sample only stalls at its end if that result has
// not been taken yet. The reference pressure is written over the cfg channel,
// which is always ready, and resets to 1013250.
// ----------------------------------------------------------------------------
module baro_pressure_to_altitude_top
    import bpa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration: reference_pressure
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [REF_W-1:0] cfg_data,     // [20:0] reference_pressure
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,      // [23:0] raw_pressure
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata       // [21:0] pressure_milli_mbar,
                                           // [53:22] altitude_mm, [55:54] zero
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic [REF_W-1:0]           ref_reg,   ref_next;
    logic signed [RAW_W-1:0]    raw_reg,   raw_next;
    logic signed [P_W-1:0]      p_reg,     p_next;
    logic signed [PROD_W-1:0]   prod_reg,  prod_next;
    logic [SEG_W-1:0]           width_reg, width_next;
    logic                       neg_reg,   neg_next;
    logic                       mv_reg,    mv_next;
    logic [P_W-1:0]             po_reg,    po_next;
    logic [ALT_W-1:0]           alt_reg,   alt_next;

    logic signed [CONV_W-1:0]   raw_ext;
    logic signed [CONV_W-1:0]   scaled;
    logic signed [CONV_W-1:0]   biased;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [DELTA_W-1:0]  factor_s;
    logic [PROD_W-1:0]          prod_mag;
    logic [ALT_W-1:0]           alt_mag;
    logic                       div_start;
    logic                       out_free;
    bpa_seg_t                   seg;
    bpa_div_stat_t              div_stat;
    logic [PROD_W-1:0]          quotient;

    // Segment lookup on the scaled pressure
    bpa_seg u_seg (
        .pressure (p_reg),
        .seg      (seg)
    );

    // Iterative divider for the altitude quotient
    bpa_div #(
        .DVD_W (PROD_W),
        .DVS_W (SEG_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_mag),
        .divisor  (width_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Scale the raw code: times 125, divide by 512 truncating toward zero
    always_comb begin
        raw_ext = {{(CONV_W-RAW_W){raw_reg[RAW_W-1]}}, raw_reg};
        scaled  = raw_ext * CONV_W'(CONV_MUL);
        biased  = scaled + (scaled[CONV_W-1] ? CONV_W'((1 << CONV_SHIFT) - 1) : CONV_W'(0));
    end

    // Difference to the reference and its product with the factor
    always_comb begin
        delta    = {{(DELTA_W-REF_W){1'b0}}, ref_reg} - {{(DELTA_W-P_W){p_reg[P_W-1]}}, p_reg};
        factor_s = {{(DELTA_W-F_W){1'b0}}, seg.factor};
        prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : prod_reg;
        alt_mag  = quotient[ALT_W-1:0];
    end

    assign div_start = (state_reg == ST_LOAD);
    assign out_free  = !mv_reg || m_tready;

    // Sequencer, configuration and output register
    always_comb begin
        state_next = state_reg;
        ref_next   = ref_reg;
        raw_next   = raw_reg;
        p_next     = p_reg;
        prod_next  = prod_reg;
        width_next = width_reg;
        neg_next   = neg_reg;
        mv_next    = mv_reg;
        po_next    = po_reg;
        alt_next   = alt_reg;

        if (cfg_valid) begin
            ref_next = cfg_data;
        end

        // drop the output once its transfer completes
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    raw_next   = s_tdata[RAW_W-1:0];
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                p_next     = biased[CONV_SHIFT+P_W-1:CONV_SHIFT];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = delta * factor_s;
                width_next = seg.width;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                neg_next   = prod_reg[PROD_W-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    po_next    = p_reg;
                    alt_next   = neg_reg ? ALT_W'(-alt_mag) : alt_mag;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ref_reg   <= REF_RESET;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ref_reg   <= ref_next;
            mv_reg    <= mv_next;
        end
        raw_reg   <= raw_next;
        p_reg     <= p_next;
        prod_reg  <= prod_next;
        width_reg <= width_next;
        neg_reg   <= neg_next;
        po_reg    <= po_next;
        alt_reg   <= alt_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = {2'b00, alt_reg, po_reg};

endmodule

// ===== rtl/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// bpa_checker: port-level checks for the pressure-to-altitude block
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module bpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // A stalled result stays offered
    a_m_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped without a transfer");

    // A stalled result keeps its data
    a_m_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // One sample at a time: no transfer right after a transfer
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready again right after a transfer");

    // A sample needs at least the scaling and multiply cycles before the next is taken
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 !s_tready)
        else $error("input ready too soon after a transfer");

    // Padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:54] == 2'b00)
        else $error("m_tdata padding not zero");

endmodule

bind baro_pressure_to_altitude_top bpa_checker u_bpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
